FILE: sv/ssp_pkg.sv
package ssp_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned BOUND_BITS = 16;
   localparam int unsigned CNT_BITS   = $clog2(WORD_BITS);

   localparam logic [WORD_BITS-1:0] HASH_INIT = 32'd1779033703;
   localparam logic [WORD_BITS-1:0] HASH_MUL  = 32'd3432918353;
   localparam logic [WORD_BITS-1:0] FIN_MUL_A = 32'd2246822507;
   localparam logic [WORD_BITS-1:0] FIN_MUL_B = 32'd3266489909;
   localparam logic [WORD_BITS-1:0] WEYL_STEP = 32'h6D2B79F5;
   localparam logic [WORD_BITS-1:0] MIX_OR    = 32'd61;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_LOAD  = 2'd2,
      CMD_DRAW  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [7:0]            seed_length;
      logic [7:0]            seed_byte;
      logic                  last_byte;
      logic [WORD_BITS-1:0]  load_value;
      logic [BOUND_BITS-1:0] bound;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  random_word;
      logic [BOUND_BITS-1:0] bounded_value;
   } rsp_type;

endpackage

FILE: sv/string_seeded_prng_with_bounded_draw.sv
// String-seeded 32-bit generator (xmur3 seeding, mulberry32 output) with a
// bounded draw.
// Request channel (req_valid/req_ready/req_data) takes one command word:
//   begin - starts the seed hash from seed_length; length 0 seeds at once
//   byte  - folds seed_byte into the hash; last_byte finishes it and seeds
//   load  - writes load_value into the generator counter
//   draw  - steps the generator and returns one response word
// Response channel (rsp_valid/rsp_ready/rsp_data) carries random_word and
// random_word modulo bound (0 when bound is 0). Only draw gives a response.
// All multiplies go through one registered 32x32 multiplier; the modulo is
// a bit-serial divider, one bit per cycle over the 32-bit word, which sets
// the draw latency. One command is in work at a time.
// A finished response sits in an output register; a new command is taken
// while it waits. A draw that completes while the old response is still
// stalled holds until rsp_ready frees the register.
// Synchronous reset clears the counter and hash to zero, drops rsp_valid.
module string_seeded_prng_with_bounded_draw (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssp_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTE_MUL,
      ST_BYTE_RES,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_DRAW1,
      ST_DRAW2,
      ST_DRAW3,
      ST_MOD,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [ssp_pkg::WORD_BITS-1:0]  acc_ff, acc_in;
   logic [ssp_pkg::WORD_BITS-1:0]  weyl_ff, weyl_in;
   logic [ssp_pkg::WORD_BITS-1:0]  t_ff, t_in;
   logic [ssp_pkg::WORD_BITS-1:0]  word_ff, word_in;
   logic                           last_ff, last_in;
   logic [ssp_pkg::BOUND_BITS-1:0] bound_ff, bound_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ssp_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [ssp_pkg::WORD_BITS-1:0]  mul_a, mul_b, prod;
   logic [ssp_pkg::WORD_BITS-1:0]  acc_start, weyl_next, mixed, rot;
   logic                           mod_start, mod_done;
   logic [ssp_pkg::BOUND_BITS-1:0] mod_rem;

   ssp_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   ssp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (word_in),
      .divisor   (bound_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      acc_start = ssp_pkg::HASH_INIT ^ {24'd0, req_data.seed_length};
      weyl_next = weyl_ff + ssp_pkg::WEYL_STEP;
      rot       = {prod[18:0], prod[31:19]};
      mixed     = (t_ff + prod) ^ t_ff;

      state_in     = state_ff;
      acc_in       = acc_ff;
      weyl_in      = weyl_ff;
      t_in         = t_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      bound_in     = bound_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mul_a        = t_ff;
      mul_b        = ssp_pkg::HASH_MUL;
      mod_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  ssp_pkg::CMD_BEGIN: begin
                     acc_in = acc_start;
                     if (req_data.seed_length == 8'd0) begin
                        t_in     = acc_start;
                        state_in = ST_FIN1;
                     end
                  end
                  ssp_pkg::CMD_BYTE: begin
                     t_in     = acc_ff ^ {24'd0, req_data.seed_byte};
                     last_in  = req_data.last_byte;
                     state_in = ST_BYTE_MUL;
                  end
                  ssp_pkg::CMD_LOAD: begin
                     weyl_in = req_data.load_value;
                  end
                  ssp_pkg::CMD_DRAW: begin
                     weyl_in  = weyl_next;
                     t_in     = weyl_next;
                     bound_in = req_data.bound;
                     state_in = ST_DRAW1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BYTE_MUL: begin
            mul_a    = t_ff;
            mul_b    = ssp_pkg::HASH_MUL;
            state_in = ST_BYTE_RES;
         end
         ST_BYTE_RES: begin
            acc_in = rot;
            if (last_ff) begin
               t_in     = rot;
               state_in = ST_FIN1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN1: begin
            mul_a    = t_ff ^ (t_ff >> 16);
            mul_b    = ssp_pkg::FIN_MUL_A;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            mul_a    = prod ^ (prod >> 13);
            mul_b    = ssp_pkg::FIN_MUL_B;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            weyl_in  = prod ^ (prod >> 16);
            state_in = ST_IDLE;
         end
         ST_DRAW1: begin
            mul_a    = t_ff ^ (t_ff >> 15);
            mul_b    = t_ff | 32'd1;
            state_in = ST_DRAW2;
         end
         ST_DRAW2: begin
            t_in     = prod;
            mul_a    = prod ^ (prod >> 7);
            mul_b    = prod | ssp_pkg::MIX_OR;
            state_in = ST_DRAW3;
         end
         ST_DRAW3: begin
            word_in = mixed ^ (mixed >> 14);
            if (bound_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               mod_start = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.random_word   = word_ff;
               rsp_data_in.bounded_value = (bound_ff == '0) ? '0 : mod_rem;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         weyl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         weyl_ff      <= weyl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      word_ff     <= word_in;
      last_ff     <= last_in;
      bound_ff    <= bound_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/ssp_mul.sv
module ssp_mul (
   input  logic                          clock,
   input  logic [ssp_pkg::WORD_BITS-1:0] op_a,
   input  logic [ssp_pkg::WORD_BITS-1:0] op_b,
   output logic [ssp_pkg::WORD_BITS-1:0] prod
);

   logic [ssp_pkg::WORD_BITS-1:0]   prod_ff;
   logic [2*ssp_pkg::WORD_BITS-1:0] full;

   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full[ssp_pkg::WORD_BITS-1:0];
   end

   assign prod = prod_ff;

endmodule

FILE: sv/ssp_mod.sv
module ssp_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ssp_pkg::WORD_BITS-1:0]  dividend,
   input  logic [ssp_pkg::BOUND_BITS-1:0] divisor,
   output logic                           done,
   output logic [ssp_pkg::BOUND_BITS-1:0] remainder
);

   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [ssp_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [ssp_pkg::BOUND_BITS-1:0] rem_ff, rem_in;
   logic [ssp_pkg::WORD_BITS-1:0]  div_ff, div_in;
   logic [ssp_pkg::BOUND_BITS-1:0] dsr_ff, dsr_in;
   logic [ssp_pkg::BOUND_BITS:0]   trial;
   logic [ssp_pkg::BOUND_BITS:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, div_ff[ssp_pkg::WORD_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = ssp_pkg::CNT_BITS'(ssp_pkg::WORD_BITS - 1);
         rem_in = '0;
         div_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[ssp_pkg::BOUND_BITS-1:0];
         end else begin
            rem_in = trial[ssp_pkg::BOUND_BITS-1:0];
         end
         div_in = {div_ff[ssp_pkg::WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/ssp_checker.sv
module ssp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ssp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ssp_pkg::rsp_type rsp_data
);

   // reset leaves the block empty and open for a command
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // only draw produces a response
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd != ssp_pkg::CMD_DRAW && !rsp_valid
      |=> !rsp_valid)
      else $error("response without draw");

   // a draw keeps the block busy
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd == ssp_pkg::CMD_DRAW |=> !req_ready)
      else $error("command taken during draw");

endmodule

bind string_seeded_prng_with_bounded_draw ssp_checker u_ssp_checker (.*);
